@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the bitplane to chunky palette unit.
// No dependencies; included by the unit's top module, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check gated off while reset is asserted
`define BPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bpc assertion failed");
// check that also runs during reset
`define BPC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bpc reset assertion failed");
`else
`define BPC_ASSERT(lbl, clk, rstn, prop)
`define BPC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ src/bpc_pkg.sv @@
// Shared types, constants and helpers for the bitplane to chunky palette unit.
// No dependencies.
`default_nettype none
package bpc_pkg;

  localparam int PLANE_COUNT = 4;   // planes that contribute index bits
  localparam int PLANE_BYTES = 4;   // plane bytes carried per beat
  localparam int SLOT_W      = 4;
  localparam int WORD_W      = 16;
  localparam int RGB_W       = 12;
  localparam int NIB_W       = 4;
  localparam int LEVEL_W     = 8;
  localparam int IDX_W       = 4;
  localparam int PAL_DEPTH   = 16;
  localparam int PIXELS      = 8;
  localparam int CNT_W       = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [0:0] {
    ACT_PALETTE = 1'b0,
    ACT_PIXEL   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_REJECT     = 2'd1,
    STAT_UNWRITTEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [RGB_W-1:0]  rgb;
  } pal_wr_t;

  typedef struct packed {
    logic             hit;
    logic [RGB_W-1:0] rgb;
  } pal_rd_t;

  // nibble * 17 is the nibble repeated
  function automatic logic [LEVEL_W-1:0] level_of(input logic [NIB_W-1:0] n);
    level_of = {n, n};
  endfunction

endpackage
`default_nettype wire

@@ src/bitplane_to_chunky_palette_unit.sv @@
// Bitplane to chunky converter with a 16-entry 12-bit RGB palette; uses bpc_pkg,
// bpc_palette and assert_macros.svh. A palette-write beat (tuser 0) gives one
// result beat; a pixel beat (tuser 1) gives eight, leftmost pixel first, with
// tlast on the eighth. Each result leaves through an output register in the cycle
// after its turn; a pixel beat holds the block for all eight results and a palette
// write for its one. One result is issued per cycle while out_tready allows. The
// next input beat is taken in the cycle the previous item's final result is
// issued, so items stream without gaps. Palette writes take effect before the
// next item is looked up.
`default_nettype none
`include "assert_macros.svh"
module bitplane_to_chunky_palette_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [3:0] color_slot, [19:4] color_word, [27:20] plane_zero_byte,
  // [35:28] plane_one_byte, [43:36] plane_two_byte, [51:44] plane_three_byte
  input  wire logic [bpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] action
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [3:0] pixel_index, [11:4] red_level, [19:12] green_level, [27:20] blue_level
  output logic [bpc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [1:0] status
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast
);

  // work register
  logic                                   work_vld_r, work_vld_nxt;
  bpc_pkg::action_t                       act_r;
  logic [bpc_pkg::SLOT_W-1:0]             slot_r;
  logic [bpc_pkg::WORD_W-1:0]             word_r;
  logic [bpc_pkg::PLANE_BYTES-1:0][7:0]   planes_r;
  logic [bpc_pkg::CNT_W-1:0]              bit_r, bit_nxt;

  // result register
  logic                                   out_vld_r, out_vld_nxt;
  logic [bpc_pkg::OUT_TDATA_W-1:0]        out_data_r, out_data_nxt;
  bpc_pkg::status_t                       out_stat_r, out_stat_nxt;
  logic                                   out_last_r, out_last_nxt;

  logic                                   in_fire;
  logic                                   adv;
  logic                                   last_res;
  logic                                   reject;
  logic [bpc_pkg::CNT_W-1:0]              sel;
  logic [bpc_pkg::IDX_W-1:0]              pix_idx;
  logic [bpc_pkg::IDX_W-1:0]              res_idx;
  logic [bpc_pkg::RGB_W-1:0]              res_rgb;
  bpc_pkg::pal_wr_t                       pal_wr;
  bpc_pkg::pal_rd_t                       pal_rd;

  assign adv      = work_vld_r && (!out_vld_r || out_tready);
  assign last_res = (act_r == bpc_pkg::ACT_PALETTE) || (&bit_r);
  assign in_tready = !work_vld_r || (adv && last_res);
  assign in_fire  = in_tvalid && in_tready;
  assign reject   = |word_r[bpc_pkg::WORD_W-1:bpc_pkg::RGB_W];
  assign sel      = ~bit_r;

  always_comb begin
    pix_idx = '0;
    for (int p = 0; p < bpc_pkg::PLANE_BYTES; p++) begin
      if (p < bpc_pkg::PLANE_COUNT) begin
        pix_idx[p] = planes_r[p][sel];
      end
    end
  end

  bpc_palette u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd_idx (pix_idx),
    .rd     (pal_rd)
  );

  always_comb begin
    pal_wr.we    = 1'b0;
    pal_wr.slot  = slot_r;
    pal_wr.rgb   = word_r[bpc_pkg::RGB_W-1:0];
    res_idx      = pix_idx;
    res_rgb      = '0;
    out_stat_nxt = bpc_pkg::STAT_OK;
    unique case (act_r)
      bpc_pkg::ACT_PALETTE: begin
        res_idx = slot_r;
        if (reject) begin
          out_stat_nxt = bpc_pkg::STAT_REJECT;
        end else begin
          res_rgb   = word_r[bpc_pkg::RGB_W-1:0];
          pal_wr.we = adv;
        end
      end
      bpc_pkg::ACT_PIXEL: begin
        if (pal_rd.hit) begin
          res_rgb = pal_rd.rgb;
        end else begin
          out_stat_nxt = bpc_pkg::STAT_UNWRITTEN;
        end
      end
    endcase
    out_data_nxt = {4'b0,
                    bpc_pkg::level_of(res_rgb[3:0]),
                    bpc_pkg::level_of(res_rgb[7:4]),
                    bpc_pkg::level_of(res_rgb[11:8]),
                    res_idx};
    out_last_nxt = last_res;
  end

  always_comb begin
    work_vld_nxt = work_vld_r;
    bit_nxt      = bit_r;
    if (in_fire) begin
      work_vld_nxt = 1'b1;
      bit_nxt      = '0;
    end else if (adv) begin
      work_vld_nxt = !last_res;
      bit_nxt      = bit_r + 1'b1;
    end
    out_vld_nxt = out_vld_r && !out_tready;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= 1'b0;
      bit_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      work_vld_r <= work_vld_nxt;
      bit_r      <= bit_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r       <= bpc_pkg::action_t'(in_tuser);
      slot_r      <= in_tdata[3:0];
      word_r      <= in_tdata[19:4];
      planes_r[0] <= in_tdata[27:20];
      planes_r[1] <= in_tdata[35:28];
      planes_r[2] <= in_tdata[43:36];
      planes_r[3] <= in_tdata[51:44];
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_stat_r <= out_stat_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  `BPC_ASSERT(a_fire_loads_work, clk, rst_n, in_fire |=> work_vld_r && (bit_r == '0))
  `BPC_ASSERT(a_last_issues_tlast, clk, rst_n, (adv && last_res) |=> out_tvalid && out_tlast)
  `BPC_ASSERT(a_reject_flagged, clk, rst_n,
    (adv && act_r == bpc_pkg::ACT_PALETTE && reject) |=>
      out_tuser == bpc_pkg::STAT_REJECT && out_tdata[bpc_pkg::OUT_TDATA_W-1:4] == '0)
  `BPC_ASSERT(a_no_accept_mid_item, clk, rst_n,
    (work_vld_r && !(adv && last_res)) |-> !in_tready)
  `BPC_ASSERT_RST(a_reset_clears, clk, !rst_n |=> !out_tvalid && !work_vld_r)

endmodule
`default_nettype wire

@@ src/bpc_palette.sv @@
// 16-entry 12-bit RGB palette with per-entry written flags.
// Depends on bpc_pkg.
`default_nettype none
module bpc_palette (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bpc_pkg::pal_wr_t           wr,
  input  wire logic [bpc_pkg::IDX_W-1:0]  rd_idx,
  output bpc_pkg::pal_rd_t                rd
);

  logic [bpc_pkg::RGB_W-1:0]     store_r [bpc_pkg::PAL_DEPTH];
  logic [bpc_pkg::PAL_DEPTH-1:0] written_r;
  logic [bpc_pkg::PAL_DEPTH-1:0] written_nxt;

  always_comb begin
    written_nxt = written_r;
    if (wr.we) begin
      written_nxt[wr.slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else begin
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      store_r[wr.slot] <= wr.rgb;
    end
  end

  always_comb begin
    rd.hit = written_r[rd_idx];
    rd.rgb = rd.hit ? store_r[rd_idx] : '0;
  end

endmodule
`default_nettype wire

@@ sim/bpc_checker.sv @@
// Scoreboard for the bitplane to chunky palette unit: watches both stream channels,
// predicts the result beats of each accepted input beat and compares them in order.
// Depends on bpc_pkg for the action and status codes and the channel widths.
`timescale 1ns / 100ps
module bpc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]                      out_tuser,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [bpc_pkg::IDX_W-1:0]   idx;
    logic [bpc_pkg::LEVEL_W-1:0] red;
    logic [bpc_pkg::LEVEL_W-1:0] green;
    logic [bpc_pkg::LEVEL_W-1:0] blue;
    bpc_pkg::status_t            status;
    logic                        last;
  } pixel_beat_t;

  logic [bpc_pkg::RGB_W-1:0]     pal_rgb [bpc_pkg::PAL_DEPTH];
  logic [bpc_pkg::PAL_DEPTH-1:0] pal_set;
  pixel_beat_t                   expected_px [$];

  function automatic logic [bpc_pkg::LEVEL_W-1:0] nib_to_level(
      logic [bpc_pkg::NIB_W-1:0] n);
    return bpc_pkg::LEVEL_W'(n * 17);
  endfunction

  task automatic predict_beat(input logic act, input logic [bpc_pkg::IN_TDATA_W-1:0] d);
    logic [bpc_pkg::SLOT_W-1:0] slot;
    logic [bpc_pkg::WORD_W-1:0] word;
    logic [7:0]                 plane [bpc_pkg::PLANE_BYTES];
    logic [bpc_pkg::IDX_W-1:0]  idx;
    pixel_beat_t                e;
    slot = d[3:0];
    word = d[19:4];
    for (int p = 0; p < bpc_pkg::PLANE_BYTES; p++) plane[p] = d[20 + 8*p +: 8];
    if (act == bpc_pkg::ACT_PALETTE) begin
      e = '0;
      e.idx  = slot;
      e.last = 1'b1;
      if (word[15:12] != '0) begin
        e.status = bpc_pkg::STAT_REJECT;
      end else begin
        pal_rgb[slot] = word[bpc_pkg::RGB_W-1:0];
        pal_set[slot] = 1'b1;
        e.red    = nib_to_level(word[11:8]);
        e.green  = nib_to_level(word[7:4]);
        e.blue   = nib_to_level(word[3:0]);
        e.status = bpc_pkg::STAT_OK;
      end
      expected_px.insert(expected_px.size(), e);
    end else begin
      for (int b = bpc_pkg::PIXELS - 1; b >= 0; b--) begin
        idx = '0;
        for (int p = 0; p < bpc_pkg::PLANE_BYTES; p++)
          if (p < bpc_pkg::PLANE_COUNT) idx[p] = plane[p][b];
        e = '0;
        e.idx  = idx;
        e.last = (b == 0);
        if (pal_set[idx]) begin
          e.red    = nib_to_level(pal_rgb[idx][11:8]);
          e.green  = nib_to_level(pal_rgb[idx][7:4]);
          e.blue   = nib_to_level(pal_rgb[idx][3:0]);
          e.status = bpc_pkg::STAT_OK;
        end else begin
          e.status = bpc_pkg::STAT_UNWRITTEN;
        end
        expected_px.insert(expected_px.size(), e);
      end
    end
  endtask

  task automatic check_beat();
    pixel_beat_t got;
    pixel_beat_t want;
    got = {out_tdata[3:0], out_tdata[11:4], out_tdata[19:12], out_tdata[27:20],
           bpc_pkg::status_t'(out_tuser), out_tlast};
    if (expected_px.size() == 0) begin
      fail_count++;
      $display("%0t unexpected beat: idx=%0d rgb=%02h/%02h/%02h st=%0d last=%0b",
               $time, got.idx, got.red, got.green, got.blue, got.status, got.last);
    end else begin
      want = expected_px.pop_front();
      if (got != want) begin
        fail_count++;
        $display("%0t mismatch: expected idx=%0d rgb=%02h/%02h/%02h st=%0d last=%0b",
                 $time, want.idx, want.red, want.green, want.blue, want.status, want.last);
        $display("%0t            actual idx=%0d rgb=%02h/%02h/%02h st=%0d last=%0b",
                 $time, got.idx, got.red, got.green, got.blue, got.status, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bpc_pkg::PAL_DEPTH; i++) pal_rgb[i] = '0;
      pal_set = '0;
      expected_px.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) predict_beat(in_tuser, in_tdata);
    end
    pending = expected_px.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the bitplane to chunky palette unit testbench: clock, reset and stream
// stimulus with random idling on both sides; bpc_checker does the scoring.
// Depends on bpc_pkg, bpc_checker and the unit RTL.
`timescale 1ns / 100ps
module tb_top;

  localparam int LIMIT     = 500000;
  localparam int LONG_HOLD = 200;
  localparam int RAND_BEATS = 400;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bpc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bpc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            out_tlast;

  int   fail_count;
  int   pending;
  int   cycle_count;
  int   hold_reqs;
  int   hold_served;
  logic tx_calm;
  logic rx_calm;
  logic in_fire;

  bitplane_to_chunky_palette_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bpc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) in_fire <= in_tvalid && in_tready;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls plus long hold-offs on request
  initial begin
    out_tready  = 1'b0;
    hold_served = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        hold_served++;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready = 1'b1;
      end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
        out_tready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_beat(bpc_pkg::action_t act, logic [bpc_pkg::SLOT_W-1:0] slot,
                           logic [bpc_pkg::WORD_W-1:0] word,
                           logic [7:0] p0, logic [7:0] p1, logic [7:0] p2, logic [7:0] p3);
    in_tuser  = act;
    in_tdata  = {4'b0, p3, p2, p1, p0, word, slot};
    in_tvalid = 1'b1;
    do @(negedge clk); while (!in_fire);
    in_tvalid = 1'b0;
    if (!tx_calm && $urandom_range(0, 99) < 35) repeat (pick_gap()) @(negedge clk);
  endtask

  task automatic send_palette(logic [bpc_pkg::SLOT_W-1:0] slot,
                              logic [bpc_pkg::WORD_W-1:0] word);
    send_beat(bpc_pkg::ACT_PALETTE, slot, word, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic send_pixels(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2, logic [7:0] p3);
    send_beat(bpc_pkg::ACT_PIXEL, 4'($urandom), 16'($urandom), p0, p1, p2, p3);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [bpc_pkg::WORD_W-1:0] word;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = bpc_pkg::ACT_PALETTE;
    hold_reqs = 0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // nothing written yet
    send_pixels(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixels(8'hff, 8'hff, 8'hff, 8'hff);
    send_palette(4'd0, 16'h0000);
    send_palette(4'd15, 16'h0fff);
    send_palette(4'd5, 16'hf123);
    send_palette(4'd6, 16'h1000);
    send_palette(4'd10, 16'h0a5c);
    send_palette(4'd3, 16'h0f0f);
    send_pixels(8'haa, 8'h55, 8'hf0, 8'h0f);
    send_pixels(8'hff, 8'hff, 8'hff, 8'hff);
    // rejected over a written slot and over an unwritten one
    send_palette(4'd15, 16'hffff);
    send_palette(4'd5, 16'h8abc);
    send_pixels(8'hff, 8'hff, 8'hff, 8'hff);
    send_pixels(8'hf0, 8'h00, 8'hf0, 8'h00);
    send_pixels(8'h81, 8'h42, 8'h24, 8'h18);
    send_palette(4'd15, 16'h0000);
    send_pixels(8'hff, 8'hff, 8'hff, 8'hff);
    wait_drained();

    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i == 100) begin
        tx_calm = 1'b1;
        hold_reqs++;
      end
      if (i == 130) begin
        tx_calm = 1'b0;
        wait_drained();
      end
      if (i == 200) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      if (i == 240) begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
      end
      if (i == 300) wait_drained();
      if ($urandom_range(0, 99) < 30) begin
        word = 16'($urandom);
        if ($urandom_range(0, 99) < 80) word[15:12] = '0;
        else if (word[15:12] == '0) word[15:12] = 4'($urandom_range(1, 15));
        send_palette(4'($urandom), word);
      end else begin
        send_pixels(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
